FILE: src/kesp_pkg.sv
package kesp_pkg;

    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    // key codes double as result kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_SCRIPT = 2'd1;
    localparam logic [1:0] KIND_IFACE  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;
    localparam logic [1:0] KEY_UNKNOWN = 2'd3;

    localparam int NUM_KEYS      = 3;
    localparam int KEY_MAX_CHARS = 8;
    localparam int LEN_BYTES     = 4;

    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX_CHARS] = '{
        '{8'h6e, 8'h61, 8'h6d, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h69, 8'h73, 8'h70, 8'h44, 8'h61, 8'h74, 8'h61},
        '{8'h71, 8'h6d, 8'h6c, 8'h46, 8'h69, 8'h6c, 8'h65, 8'h00}
    };
    localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd4, 4'd8, 4'd7};

    localparam int          RESQ_DEPTH = 4;
    localparam int          RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam logic [31:0] PLEN_RESET = 32'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic       first_of_value;
        logic       last_of_value;
        logic       empty_value;
        logic       status;
    } t_result;

endpackage

FILE: src/keyed_entry_stream_parser_core.sv
// Parses a decompressed package of entries (zero-terminated key, 4-byte big-endian length,
// value) one byte per cycle: the byte is decoded in the cycle it is accepted, so the input
// takes a transaction every cycle while the 4-entry result queue has room for two results.
// Value bytes of "name", "lispData" and "qmlFile" leave tagged by kind (tuser) with first
// and last marks; a byte with tlast adds an end-status result after any value result, which
// is the only case where one input byte yields two results and the queue briefly fills.
// Parsing stops for the rest of the package when a length field or value would run past
// payload_length. The user writes the length register (i_cfg_we) while idle; not enforced.
module keyed_entry_stream_parser_core
    import kesp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] value_byte, [8] first_of_value,
                                     // [9] empty_value, [10] status, [15:11] zero
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast    // last_of_value
);

    logic [31:0] r_plen;
    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [3:0]  r_key_idx, n_key_idx;
    logic [2:0]  r_flags, n_flags;
    logic [31:0] r_len_shift, n_len_shift;
    logic [1:0]  r_len_seen, n_len_seen;
    logic [31:0] r_val_rem, n_val_rem;
    logic [1:0]  r_cur_key, n_cur_key;
    logic        r_script, n_script;
    logic        r_iface, n_iface;

    t_result     r_q [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [RESQ_AW:0]   r_count;

    logic        s_acc, m_acc;
    t_result     val_res, end_res, push0, push1;
    logic        val_vld, end_vld;
    logic [1:0]  push_cnt;
    t_phase      ph;
    logic [1:0]  code;
    logic [31:0] shift_new, rem_dec;

    assign o_s_tready = (r_count <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
    assign s_acc      = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = (r_count != '0);
    assign m_acc      = o_m_tvalid & i_m_tready;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_key_idx   = r_key_idx;
        n_flags     = r_flags;
        n_len_shift = r_len_shift;
        n_len_seen  = r_len_seen;
        n_val_rem   = r_val_rem;
        n_cur_key   = r_cur_key;
        n_script    = r_script;
        n_iface     = r_iface;
        val_res     = '0;
        end_res     = '0;
        val_vld     = 1'b0;
        end_vld     = 1'b0;
        code        = KEY_UNKNOWN;
        shift_new   = {r_len_shift[23:0], i_s_tdata};
        rem_dec     = r_val_rem - 32'd1;
        ph          = (r_pos >= r_plen) ? PH_STOP : r_phase;
        if (s_acc) begin
            n_phase = ph;
            unique case (ph)
                PH_KEY: begin
                    if (i_s_tdata == 8'd0) begin
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (r_flags[k] && r_key_idx == KEY_LEN[k]) begin
                                code = 2'(k);
                            end
                        end
                        n_cur_key   = code;
                        n_key_idx   = '0;
                        n_flags     = '1;
                        n_len_shift = '0;
                        n_len_seen  = '0;
                        n_phase     = ({1'b0, r_pos} + 33'(LEN_BYTES + 1) > {1'b0, r_plen})
                                      ? PH_STOP : PH_LEN;
                    end else begin
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (r_key_idx >= KEY_LEN[k] ||
                                KEY_TEXT[k][r_key_idx[2:0]] != i_s_tdata) begin
                                n_flags[k] = 1'b0;
                            end
                        end
                        if (r_key_idx != 4'hf) begin
                            n_key_idx = r_key_idx + 4'd1;
                        end
                    end
                end
                PH_LEN: begin
                    n_len_shift = shift_new;
                    if (r_len_seen == 2'(LEN_BYTES - 1)) begin
                        n_len_seen = '0;
                        if ({1'b0, r_pos} + {1'b0, shift_new} + 33'd1 > {1'b0, r_plen}) begin
                            n_phase = PH_STOP;
                        end else if (shift_new == '0) begin
                            if (r_cur_key != KEY_UNKNOWN) begin
                                val_vld                = 1'b1;
                                val_res.kind           = r_cur_key;
                                val_res.first_of_value = 1'b1;
                                val_res.last_of_value  = 1'b1;
                                val_res.empty_value    = 1'b1;
                            end
                            if (r_cur_key == KIND_SCRIPT) n_script = 1'b0;
                            if (r_cur_key == KIND_IFACE)  n_iface  = 1'b0;
                            n_phase = PH_KEY;
                        end else begin
                            if (r_cur_key == KIND_SCRIPT) n_script = 1'b1;
                            if (r_cur_key == KIND_IFACE)  n_iface  = 1'b1;
                            n_val_rem = shift_new;
                            n_phase   = PH_VAL;
                        end
                    end else begin
                        n_len_seen = r_len_seen + 2'd1;
                    end
                end
                PH_VAL: begin
                    if (r_cur_key != KEY_UNKNOWN) begin
                        val_vld                = 1'b1;
                        val_res.kind           = r_cur_key;
                        val_res.value_byte     = i_s_tdata;
                        val_res.first_of_value = (r_val_rem == r_len_shift);
                        val_res.last_of_value  = (r_val_rem == 32'd1);
                    end
                    if (r_val_rem != '0) begin
                        n_val_rem = rem_dec;
                    end
                    if (r_val_rem == '0 || rem_dec == '0) begin
                        n_phase = PH_KEY;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase
            if (r_pos != '1) begin
                n_pos = r_pos + 32'd1;
            end
            if (i_s_tlast) begin
                end_vld        = 1'b1;
                end_res.kind   = KIND_END;
                end_res.status = !(n_script || n_iface);
                n_phase        = PH_KEY;
                n_pos          = '0;
                n_key_idx      = '0;
                n_flags        = '1;
                n_len_shift    = '0;
                n_len_seen     = '0;
                n_val_rem      = '0;
                n_cur_key      = KEY_UNKNOWN;
                n_script       = 1'b0;
                n_iface        = 1'b0;
            end
        end
        push0    = val_vld ? val_res : end_res;
        push1    = end_res;
        push_cnt = {1'b0, val_vld} + {1'b0, end_vld};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= PLEN_RESET;
            r_phase     <= PH_KEY;
            r_pos       <= '0;
            r_key_idx   <= '0;
            r_flags     <= '1;
            r_len_shift <= '0;
            r_len_seen  <= '0;
            r_val_rem   <= '0;
            r_cur_key   <= KEY_UNKNOWN;
            r_script    <= 1'b0;
            r_iface     <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_key_idx   <= n_key_idx;
            r_flags     <= n_flags;
            r_len_shift <= n_len_shift;
            r_len_seen  <= n_len_seen;
            r_val_rem   <= n_val_rem;
            r_cur_key   <= n_cur_key;
            r_script    <= n_script;
            r_iface     <= n_iface;
            r_wr_ptr    <= r_wr_ptr + RESQ_AW'(push_cnt);
            if (m_acc) begin
                r_rd_ptr <= r_rd_ptr + RESQ_AW'(1);
            end
            r_count <= r_count + (RESQ_AW+1)'(push_cnt) - (RESQ_AW+1)'(m_acc);
        end
    end

    // result queue storage, up to two writes per transaction
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= push0;
        end
        if (push_cnt == 2'd2) begin
            r_q[r_wr_ptr + RESQ_AW'(1)] <= push1;
        end
    end

    assign o_m_tdata = {5'd0, r_q[r_rd_ptr].status, r_q[r_rd_ptr].empty_value,
                        r_q[r_rd_ptr].first_of_value, r_q[r_rd_ptr].value_byte};
    assign o_m_tuser = r_q[r_rd_ptr].kind;
    assign o_m_tlast = r_q[r_rd_ptr].last_of_value;

endmodule
